// ----- hw/rtl/mshw_pkg.sv -----
// ----------------------------------------------------------------------------
// mshw_pkg
// Shared command codes and fixed field widths of the multi-slot heartbeat
// watchdog.
// ----------------------------------------------------------------------------
package mshw_pkg;

	// fixed field widths of the command and response words
	localparam int CMD_W  = 3;
	localparam int SLOT_W = 4;
	localparam int DUR_W  = 24;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ARM    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISARM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INJECT = 3'd4;

endpackage

// ----- hw/rtl/mshw_slot_ram.sv -----
// ----------------------------------------------------------------------------
// mshw_slot_ram
// Per-slot deadline store: one write port, one read port, registered read
// data. Each entry has a valid bit cleared by reset; an entry never
// written since reset reads as zero (disarmed).
// ----------------------------------------------------------------------------
module mshw_slot_ram #(
	parameter int DEPTH = 16,
	parameter int DW    = 96,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DW-1:0]    data_s1;
	logic             vld_s1;

	// storage array and registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
		end
	end

	// entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entries read as disarmed
	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

// ----- hw/rtl/multi_slot_heartbeat_watchdog.sv -----
// ----------------------------------------------------------------------------
// multi_slot_heartbeat_watchdog
// Tick counter plus per-slot warning and fatal deadlines held in a
// synchronous RAM; answers tick, arm, disarm, query and inject commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (cmd_valid / cmd_stall) takes one word: cmd, slot,
//   duration, fatal_duration. Response channel (rsp_valid / rsp_stall) gives
//   one word per command: healthy and the sticky fatal flag.
//   The block works on one command at a time; cmd_stall is high while it is
//   busy. Steps from the accepting edge to response valid:
//     tick, unused codes, arm/disarm of a slot out of range: output
//     arm/disarm: RAM read, examine and write back, output
//     query/inject: one registered RAM read per slot, then output
//   The next command is taken the cycle after the response register loads,
//   so no new command is taken before the last one is answered.
//   A finished response waits in the output register while rsp_stall is
//   high; a next result then holds in the output state and stalls commands.
//   Reset clears the clock, all deadlines (per-entry valid bits in the RAM),
//   the injection end and the fatal flag; no clearing pass is needed.
//   Times saturate at all ones instead of wrapping.
// ----------------------------------------------------------------------------
module multi_slot_heartbeat_watchdog
	import mshw_pkg::*;
#(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [SLOT_W-1:0] slot,
	input  logic [DUR_W-1:0]  duration,
	input  logic [DUR_W-1:0]  fatal_duration,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic              healthy,
	output logic              fatal
);

	localparam int TB = TIME_BITS;
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = 9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLOT_EX,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [TB-1:0] warn;
		logic [TB-1:0] fat;
	} entry_t;

	state_t         state_q;
	logic [TB-1:0]  now_q;
	logic [TB-1:0]  inject_q;
	logic           fatal_q;
	logic           res_h_q;
	logic [AW-1:0]  idx_q;
	logic           disarm_q;
	logic [TB-1:0]  warn_sum_q;
	logic [TB-1:0]  fatal_sum_q;
	logic [CW-1:0]  cnt_q;
	logic           scan_pend_s1;
	logic           scan_last_s1;
	logic           rsp_valid_q;
	logic           healthy_q;
	logic           fatal_out_q;

	logic           accept;
	logic [XW-1:0]  slot_x;
	logic           in_range;
	logic [TB-1:0]  tick_next;
	logic [TB-1:0]  warn_sum;
	logic [TB-1:0]  fatal_sum;
	logic [TB-1:0]  inject_next;
	logic           scan_issue;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;
	entry_t         wr_entry;
	entry_t         rd_entry;
	logic           ex_ok;
	logic           ex_fatal;

	// saturating add of two times
	function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
	                                          input logic [TB-1:0] b);
		logic [TB:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TB] ? {TB{1'b1}} : s[TB-1:0];
	endfunction

	assign accept   = cmd_valid && !cmd_stall;
	assign slot_x   = XW'(slot);
	assign in_range = slot_x < XW'(SLOTS);

	// deadline sums from the incoming word
	assign tick_next   = sat_add(now_q, TB'(1));
	assign warn_sum    = sat_add(now_q, TB'(duration));
	assign fatal_sum   = (fatal_duration != '0) ? sat_add(now_q, TB'(fatal_duration)) : '0;
	assign inject_next = (cmd == CMD_INJECT && duration != '0) ? warn_sum : inject_q;

	// RAM read: single slot on arm/disarm, one slot per cycle while scanning
	assign scan_issue = (state_q == ST_SCAN) && (cnt_q < CW'(SLOTS));
	assign rd_en      = scan_issue ||
	                    (accept && in_range && (cmd == CMD_ARM || cmd == CMD_DISARM));
	assign rd_addr    = (state_q == ST_SCAN) ? cnt_q[AW-1:0] : slot_x[AW-1:0];

	// write back after examining the slot
	assign wr_en         = (state_q == ST_SLOT_EX);
	assign wr_entry.warn = disarm_q ? '0 : warn_sum_q;
	assign wr_entry.fat  = disarm_q ? '0 : fatal_sum_q;

	// examine the entry that came back from the RAM
	assign ex_ok    = !(rd_entry.warn != '0 && rd_entry.warn < now_q);
	assign ex_fatal = rd_entry.fat != '0 && rd_entry.fat < now_q;

	mshw_slot_ram #(
		.DEPTH (SLOTS),
		.DW    (2 * TB),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_entry),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data (wr_entry)
	);

	// datapath registers captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q       <= slot_x[AW-1:0];
			disarm_q    <= (cmd == CMD_DISARM);
			warn_sum_q  <= warn_sum;
			fatal_sum_q <= fatal_sum;
		end
	end

	// control state machine and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			inject_q     <= '0;
			fatal_q      <= 1'b0;
			res_h_q      <= 1'b1;
			cnt_q        <= '0;
			scan_pend_s1 <= 1'b0;
			scan_last_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
			healthy_q    <= 1'b1;
			fatal_out_q  <= 1'b0;
		end else begin
			// output state reloads the register itself
			if (rsp_valid_q && !rsp_stall && state_q != ST_OUT) begin
				rsp_valid_q <= 1'b0;
			end
			scan_pend_s1 <= scan_issue;
			scan_last_s1 <= scan_issue && (cnt_q == CW'(SLOTS - 1));

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_h_q <= 1'b1;
						state_q <= ST_OUT;
						case (cmd)
							CMD_TICK: begin
								now_q <= tick_next;
							end
							CMD_ARM, CMD_DISARM: begin
								if (in_range) begin
									state_q <= ST_SLOT_EX;
								end
							end
							CMD_QUERY, CMD_INJECT: begin
								inject_q <= inject_next;
								res_h_q  <= !(now_q < inject_next);
								cnt_q    <= '0;
								state_q  <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SLOT_EX: begin
					res_h_q <= ex_ok;
					if (ex_fatal) begin
						fatal_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (scan_pend_s1) begin
						if (!ex_ok) begin
							res_h_q <= 1'b0;
						end
						if (ex_fatal) begin
							fatal_q <= 1'b1;
						end
						if (scan_last_s1) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						healthy_q   <= res_h_q;
						fatal_out_q <= fatal_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign healthy   = healthy_q;
	assign fatal     = fatal_out_q;

endmodule
